>>> hdl/sae_pkg.sv
// Shared types and constants for the stable argsort engine.
`default_nettype none
package sae_pkg;

   localparam int KEY_W             = 32;
   localparam int POS_W             = 4;
   localparam int MAX_ITEMS_DEFAULT = 16;

   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        pos;
   } entry_type;

   typedef struct packed {
      logic load;
      logic drain;
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> hdl/sae_cell.sv
// One cell of the insertion chain: holds one sorted entry and shifts with its neighbors.
`default_nettype none
module sae_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sae_pkg::cell_ctrl_type ctrl,
   input  sae_pkg::entry_type    new_entry,
   input  sae_pkg::entry_type    left_entry,
   input  sae_pkg::entry_type    right_entry,
   input  logic                  left_ins,
   output sae_pkg::entry_type    entry,
   output logic                  ins
);
   import sae_pkg::*;

   logic                    valid_ff, valid_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   assign ins = !valid_ff || ($signed(key_ff) > $signed(new_entry.key));

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      if (ctrl.drain) begin
         valid_in = right_entry.valid;
         key_in   = right_entry.key;
         pos_in   = right_entry.pos;
      end else if (ctrl.load) begin
         if (left_ins) begin
            valid_in = left_entry.valid;
            key_in   = left_entry.key;
            pos_in   = left_entry.pos;
         end else if (ins) begin
            valid_in = new_entry.valid;
            key_in   = new_entry.key;
            pos_in   = new_entry.pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in;
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.pos   = pos_ff;

endmodule
`default_nettype wire

>>> hdl/stable_argsort_engine.sv
// Stable ascending argsort engine: insertion cell chain with in-order drain.
//
// Keys arrive on the req_ channel, one item per cycle while loading. Each
// accepted key is placed into a chain of MAX_ITEMS cells, where every
// cell compares its key with the incoming key, and the cells above the
// insertion point shift one place up, so the chain is always sorted. Equal
// keys stay in load order. Keys arriving while the chain is full are dropped
// and the set is flagged.
// An item with req_last_key set closes the set. From the next cycle the
// chain drains from its bottom cell on the rsp_ channel, one result per
// cycle while rsp_ready is high. req_ready is low for the whole drain; a stall
// on rsp_ready holds the chain and the presented result. rsp_last_rank marks
// the final result, after which the block takes keys of the next set at once.
// Reset empties the chain and clears the drop flag; no clearing pass is
// needed.
`default_nettype none
module stable_argsort_engine #(
   parameter int MAX_ITEMS = sae_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [sae_pkg::KEY_W-1:0] req_key,
   input  logic                             req_last_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sae_pkg::POS_W-1:0]        rsp_rank_index,
   output logic signed [sae_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic                             rsp_last_rank,
   output logic                             rsp_keys_dropped
);
   import sae_pkg::*;

   logic             drain_ff, drain_in;
   logic             overflow_ff, overflow_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   entry_type        ent [MAX_ITEMS];
   logic             ins [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] valid_vec;
   entry_type        new_entry;
   entry_type        empty_entry;
   cell_ctrl_type    ctrl;

   logic req_acc, rsp_acc, full, final_acc;

   assign req_ready = !drain_ff;
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign full      = ent[MAX_ITEMS-1].valid;
   assign final_acc = rsp_acc && rsp_last_rank;

   assign new_entry.valid   = 1'b1;
   assign new_entry.key     = req_key;
   assign new_entry.pos     = pos_ff;
   assign empty_entry.valid = 1'b0;
   assign empty_entry.key   = '0;
   assign empty_entry.pos   = '0;

   assign ctrl.load  = req_acc && !full;
   assign ctrl.drain = rsp_acc;

   genvar g;
   generate
      for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
         sae_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  ((g == 0) ? empty_entry : ent[(g == 0) ? 0 : g-1]),
            .right_entry ((g == MAX_ITEMS-1) ? empty_entry
                          : ent[(g == MAX_ITEMS-1) ? g : g+1]),
            .left_ins    ((g == 0) ? 1'b0 : ins[(g == 0) ? 0 : g-1]),
            .entry       (ent[g]),
            .ins         (ins[g])
         );
         assign valid_vec[g] = ent[g].valid;
      end
   endgenerate

   always_comb begin
      drain_in    = drain_ff;
      overflow_in = overflow_ff;
      pos_in      = pos_ff;
      if (final_acc) begin
         drain_in    = 1'b0;
         overflow_in = 1'b0;
         pos_in      = '0;
      end else if (req_acc) begin
         if (req_last_key) begin
            drain_in = 1'b1;
         end
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff    <= 1'b0;
         overflow_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         drain_ff    <= drain_in;
         overflow_ff <= overflow_in;
         pos_ff      <= pos_in;
      end
   end

   assign rsp_valid        = drain_ff;
   assign rsp_rank_index   = ent[0].pos;
   assign rsp_sorted_key   = ent[0].key;
   assign rsp_last_rank    = !ent[1].valid;
   assign rsp_keys_dropped = overflow_ff;

   a_rsp_has_entry : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ent[0].valid)
      else $error("result presented from an empty chain");

   a_chain_prefix : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("chain holds a gap");

   a_set_closes : assert property (@(posedge clock) disable iff (reset)
      final_acc |=> (!rsp_valid && pos_ff == '0 && !overflow_ff && valid_vec == '0))
      else $error("set not cleared after final result");

   a_drop_when_full : assert property (@(posedge clock) disable iff (reset)
      (overflow_ff && !drain_ff) |-> full)
      else $error("drop flag set while chain not full");

endmodule
`default_nettype wire

>>> tb/sv/tb_stable_argsort_engine.sv
// Testbench for stable_argsort_engine: random key sets checked against a stable insertion sort.
`timescale 1ns / 100ps
module tb_stable_argsort_engine;

   localparam int DEPTH     = sae_pkg::MAX_ITEMS_DEFAULT;
   localparam int KW        = sae_pkg::KEY_W;
   localparam int PW        = sae_pkg::POS_W;
   localparam int IDLE_PCT  = 22;
   localparam int CALM_LO   = 120;
   localparam int CALM_HI   = 200;
   localparam int RAND_KEYS = 360;

   typedef struct {
      logic signed [KW-1:0] key;
      logic                 last;
   } key_item_t;

   typedef struct {
      logic [PW-1:0]        rank;
      logic signed [KW-1:0] key;
      logic                 last;
      logic                 dropped;
   } rank_result_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [KW-1:0] req_key = '0;
   logic                 req_last_key = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PW-1:0]        rsp_rank_index;
   logic signed [KW-1:0] rsp_sorted_key;
   logic                 rsp_last_rank;
   logic                 rsp_keys_dropped;

   key_item_t    key_feed_q[$];
   rank_result_t ranked_q[$];
   int           keys_total = 0;
   int           keys_taken = 0;
   int           errors = 0;
   logic         req_taken = 1'b0;

   logic signed [KW-1:0] sorted_keys[DEPTH];
   logic [PW-1:0]        sorted_pos[DEPTH];
   int                   sorted_count = 0;
   logic                 set_overflow = 1'b0;

   stable_argsort_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key          (req_key),
      .req_last_key     (req_last_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank_index   (rsp_rank_index),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_last_rank    (rsp_last_rank),
      .rsp_keys_dropped (rsp_keys_dropped)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // insert behind all keys <= k; on the last key, emit ranks in order and close the set
   task automatic absorb_key(input logic signed [KW-1:0] k, input logic last);
      int           p;
      int           i;
      rank_result_t r;
      if (sorted_count >= DEPTH) begin
         set_overflow = 1'b1;
      end else begin
         p = 0;
         while (p < sorted_count && sorted_keys[p] <= k) p++;
         for (i = sorted_count; i > p; i--) begin
            sorted_keys[i] = sorted_keys[i-1];
            sorted_pos[i]  = sorted_pos[i-1];
         end
         sorted_keys[p] = k;
         sorted_pos[p]  = PW'(sorted_count);
         sorted_count++;
      end
      if (last) begin
         for (i = 0; i < sorted_count; i++) begin
            r.rank    = sorted_pos[i];
            r.key     = sorted_keys[i];
            r.last    = (i + 1 == sorted_count);
            r.dropped = set_overflow;
            ranked_q  = {ranked_q, r};
         end
         sorted_count = 0;
         set_overflow = 1'b0;
      end
   endtask

   task automatic queue_key(input logic signed [KW-1:0] k, input logic last);
      key_item_t it;
      it.key  = k;
      it.last = last;
      key_feed_q = {key_feed_q, it};
      keys_total++;
   endtask

   function automatic logic signed [KW-1:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return KW'($signed($urandom_range(8)) - 4);
      if (sel < 55) begin
         case ($urandom_range(3))
            0: return {1'b1, {(KW-1){1'b0}}};
            1: return {1'b0, {(KW-1){1'b1}}};
            2: return '1;
            default: return '0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic calm();
      return keys_taken >= CALM_LO && keys_taken < CALM_HI;
   endfunction

   always @(negedge clock) begin : feed
      key_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (key_feed_q.size() != 0 && (calm() || $urandom_range(99) >= IDLE_PCT)) begin
            it = key_feed_q.pop_front();
            req_valid    <= 1'b1;
            req_key      <= it.key;
            req_last_key <= it.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && (calm() || $urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : watch
      rank_result_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            absorb_key(req_key, req_last_key);
            keys_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (ranked_q.size() == 0) begin
               $display("%0t: unexpected result rank_index=%0d sorted_key=%0d",
                        $time, rsp_rank_index, rsp_sorted_key);
               errors++;
            end else begin
               want = ranked_q.pop_front();
               if (rsp_rank_index !== want.rank) begin
                  $display("%0t: rank_index expected %0d actual %0d",
                           $time, want.rank, rsp_rank_index);
                  errors++;
               end
               if (rsp_sorted_key !== want.key) begin
                  $display("%0t: sorted_key expected %0d actual %0d",
                           $time, want.key, rsp_sorted_key);
                  errors++;
               end
               if (rsp_last_rank !== want.last) begin
                  $display("%0t: last_rank expected %0b actual %0b",
                           $time, want.last, rsp_last_rank);
                  errors++;
               end
               if (rsp_keys_dropped !== want.dropped) begin
                  $display("%0t: keys_dropped expected %0b actual %0b",
                           $time, want.dropped, rsp_keys_dropped);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      int len;
      int sel;
      int rand_keys;
      // single-key sets at both extremes
      queue_key({1'b0, {(KW-1){1'b1}}}, 1'b1);
      queue_key({1'b1, {(KW-1){1'b0}}}, 1'b1);
      // equal keys keep load order, mixed with extremes
      queue_key(32'sd5, 1'b0);
      queue_key(-32'sd1, 1'b0);
      queue_key(32'sd5, 1'b0);
      queue_key({1'b1, {(KW-1){1'b0}}}, 1'b0);
      queue_key({1'b0, {(KW-1){1'b1}}}, 1'b0);
      queue_key(32'sd5, 1'b1);
      // full store, then a dropped last key
      for (i = 0; i < DEPTH; i++) queue_key(KW'(DEPTH - 1 - i) - 32'sd8, 1'b0);
      queue_key(32'sd0, 1'b1);
      rand_keys = 0;
      while (rand_keys < RAND_KEYS) begin
         sel = $urandom_range(99);
         if (sel < 8) len = $urandom_range(DEPTH + 4, DEPTH + 1);
         else if (sel < 20) len = DEPTH;
         else len = $urandom_range(DEPTH - 1, 1);
         for (i = 0; i < len; i++) queue_key(pick_key(), i == len - 1);
         rand_keys += len;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (keys_taken < keys_total || ranked_q.size() != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #3600000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
